// File: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL.
// Clocked on clk, ignored while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge.
`define UPQ_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define UPQ_ASSERT_NEXT(lbl, trig, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (expr)) else $error(msg);

// Check that a condition holds in the same cycle as a trigger.
`define UPQ_ASSERT_SAME(lbl, trig, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (expr)) else $error(msg);

`endif

// File: rtl/core/upq_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// upq_pkg
// Types and constants for the urgent-class priority queue.
// ---------------------------------------------------------------------------
package upq_pkg;

  localparam int unsigned DEPTH_DEFAULT = 16;
  localparam logic [3:0]  URGENT_RESET  = 4'd2;
  localparam int unsigned OCC_W         = 5;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_REMOVED  = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } upq_status_t;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_EXEC = 1'b1
  } upq_state_t;

  typedef struct packed {
    logic               action;
    logic [15:0]        app_code;
    logic [31:0]        transaction_number;
    logic signed [31:0] sql_code;
    logic [3:0]         priority_req;
  } upq_in_t;

  typedef struct packed {
    upq_status_t        status;
    logic [15:0]        app_code_out;
    logic [31:0]        transaction_out;
    logic signed [31:0] sql_code_out;
    logic [3:0]         priority_out;
    logic [OCC_W-1:0]   occupancy;
  } upq_out_t;

  typedef struct packed {
    logic [15:0]        app;
    logic [31:0]        txn;
    logic signed [31:0] sql;
    logic [3:0]         prio;
  } upq_entry_t;

  // controller to datapath
  typedef struct packed {
    logic load;  // capture request beat
    logic exec;  // apply captured request to the queue
  } upq_cmd_t;

endpackage

// File: rtl/core/upq_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// upq_ctrl
// Two-state sequencer: takes a request in IDLE, then applies it in EXEC.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module upq_ctrl
  import upq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  output upq_cmd_t cmd
);

  upq_state_t state_r;
  upq_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FSM_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    busy      = 1'b0;
    cmd       = '0;
    case (state_r)
      FSM_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = FSM_EXEC;
        end
      end
      FSM_EXEC: begin
        busy      = 1'b1;
        cmd.exec  = 1'b1;
        state_nxt = FSM_IDLE;
      end
      default: begin
        state_nxt = FSM_IDLE;
      end
    endcase
  end

  `UPQ_ASSERT_NEXT(a_exec_once, cmd.exec, !cmd.exec, "exec held for more than one cycle")
  `UPQ_ASSERT_NEXT(a_load_exec, cmd.load, cmd.exec, "captured beat not applied next cycle")
  `UPQ_ASSERT_ALWAYS(a_cmd_excl, !(cmd.load && cmd.exec), "load and exec together")

endmodule

// File: rtl/core/upq_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// upq_datapath
// Entry array with per-cell compare, insert/remove shift, result register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module upq_datapath
  import upq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst_n,
  input  upq_cmd_t   cmd,
  input  upq_in_t    in_data,
  input  logic       cfg_we,
  input  logic [3:0] cfg_urgent,
  output logic       out_valid,
  output upq_out_t   out_data
);

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  upq_in_t         req_r;
  logic [3:0]      urgent_r;
  logic [CntW-1:0] count_r;
  logic [CntW-1:0] count_nxt;
  upq_entry_t      entry_r   [QUEUE_DEPTH];
  upq_entry_t      entry_nxt [QUEUE_DEPTH];
  logic            out_valid_r;
  upq_out_t        out_r;
  upq_out_t        out_nxt;

  logic [QUEUE_DEPTH-1:0] is_urg;   // live cell holding the urgent level
  logic [QUEUE_DEPTH-1:0] is_ge;    // live cell with priority >= request
  logic [QUEUE_DEPTH-1:0] ahead;    // cell stays ahead of the new entry
  logic                   full;
  logic                   empty;
  logic                   req_urg;
  upq_entry_t             new_e;
  logic                   res_clean; // data fields zero unless an entry left

  assign full    = (count_r == CntW'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign req_urg = (req_r.priority_req == urgent_r);
  assign new_e   = '{app:  req_r.app_code,
                     txn:  req_r.transaction_number,
                     sql:  req_r.sql_code,
                     prio: req_r.priority_req};

  // per-cell compares, all in parallel
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      is_urg[i] = (CntW'(i) < count_r) && (entry_r[i].prio == urgent_r);
      is_ge[i]  = (CntW'(i) < count_r) && (entry_r[i].prio >= req_r.priority_req);
    end
  end

  // prefix: leading urgent run, then (non-urgent request) cells >= request
  always_comb begin
    logic run_u;
    logic keep;
    run_u = 1'b1;
    keep  = 1'b1;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      run_u    = run_u & is_urg[i];
      keep     = keep & (req_urg ? run_u : (run_u | is_ge[i]));
      ahead[i] = keep;
    end
  end

  // next array contents and result
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      entry_nxt[i] = entry_r[i];
    end
    count_nxt = count_r;
    out_nxt   = '0;
    if (req_r.action == ACT_INSERT) begin
      if (full) begin
        out_nxt.status = ST_FULL;
      end else begin
        out_nxt.status = ST_INSERTED;
        count_nxt      = count_r + 1'b1;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
          if (!ahead[i]) begin
            if (i == 0) begin
              entry_nxt[i] = new_e;
            end else if (ahead[i-1]) begin
              entry_nxt[i] = new_e;
            end else begin
              entry_nxt[i] = entry_r[i-1];
            end
          end
        end
      end
    end else begin
      if (empty) begin
        out_nxt.status = ST_EMPTY;
      end else begin
        out_nxt.status          = ST_REMOVED;
        out_nxt.app_code_out    = entry_r[0].app;
        out_nxt.transaction_out = entry_r[0].txn;
        out_nxt.sql_code_out    = entry_r[0].sql;
        out_nxt.priority_out    = entry_r[0].prio;
        count_nxt               = count_r - 1'b1;
        for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
          entry_nxt[i] = entry_r[i+1];
        end
      end
    end
    out_nxt.occupancy = OCC_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      urgent_r    <= URGENT_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        urgent_r <= cfg_urgent;
      end
      if (cmd.exec) begin
        count_r <= count_nxt;
      end
      out_valid_r <= cmd.exec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_data;
    end
    if (cmd.exec) begin
      out_r <= out_nxt;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        entry_r[i] <= entry_nxt[i];
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign res_clean = !out_valid_r || (out_r.status == ST_REMOVED) ||
                     ((out_r.app_code_out == '0) && (out_r.transaction_out == '0) &&
                      (out_r.sql_code_out == '0) && (out_r.priority_out == '0));

  `UPQ_ASSERT_ALWAYS(a_count_max, count_r <= CntW'(QUEUE_DEPTH), "entry count above depth")
  `UPQ_ASSERT_NEXT(a_count_hold, !cmd.exec, $stable(count_r), "count moved without exec")
  `UPQ_ASSERT_ALWAYS(a_zero_data, res_clean, "data not zero")

endmodule

// File: rtl/core/urgent_class_priority_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// urgent_class_priority_queue
// Bounded request queue: urgent class first in arrival order, then by
// descending priority with stable ties.
// ---------------------------------------------------------------------------
// Pulse start with a request beat while busy is low. The beat is captured at
// that edge; busy is high for the next cycle, in which the whole entry array
// compares every cell against the request in parallel and shifts in one
// step. The result appears on out_data with out_valid high for exactly one
// cycle, the cycle after busy; there is no back-pressure, so the receiver
// must take it then. A new beat may be presented in that same result cycle,
// but no new request is taken until the previous one has been applied by
// the array. Result status: inserted, removed (head fields returned), queue
// empty or queue full; the data fields are zero unless an entry was removed.
// occupancy is the count after the step, truncated to 5 bits. The urgent
// priority level (reset 2) is written over the cfg channel, which is always
// ready; write it only while no request is in flight. No clearing pass is
// needed after reset: cells above the count are never read.
// ---------------------------------------------------------------------------
module urgent_class_priority_queue
  import upq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst_n,
  // request beats
  input  logic       start,
  output logic       busy,
  input  upq_in_t    in_data,
  // result beats
  output logic       out_valid,
  output upq_out_t   out_data,
  // urgent level register
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [3:0] cfg_data
);

  upq_cmd_t cmd;

  assign cfg_ready = 1'b1;

  upq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  upq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_data    (in_data),
    .cfg_we     (cfg_valid & cfg_ready),
    .cfg_urgent (cfg_data),
    .out_valid  (out_valid),
    .out_data   (out_data)
  );

endmodule
